@@ design/ps2_mouse_command_responder_top_macros.svh @@
// assertion macros for the checker file
`ifndef PS2_MOUSE_COMMAND_RESPONDER_TOP_MACROS_SVH
`define PS2_MOUSE_COMMAND_RESPONDER_TOP_MACROS_SVH

// same-cycle implication, off while reset is low
`define PS2M_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define PS2M_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ps2m_pkg.sv @@
package ps2m_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] OP_HOST_CMD = 2'd0;
    localparam logic [1:0] OP_MOVEMENT = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_SOFT_RST = 2'd3;

    localparam logic [7:0] CMD_RESET        = 8'hFF;
    localparam logic [7:0] CMD_SET_DEFAULTS = 8'hF6;
    localparam logic [7:0] CMD_DISABLE      = 8'hF5;
    localparam logic [7:0] CMD_ENABLE       = 8'hF4;
    localparam logic [7:0] CMD_GET_ID       = 8'hF2;

    localparam logic [7:0] REPLY_ACK       = 8'hFA;
    localparam logic [7:0] REPLY_SELF_TEST = 8'hAA;
    localparam logic [7:0] REPLY_ID        = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic push;
        logic pop;
        logic finish;
    } t_ctrl;

endpackage

@@ design/ps2_mouse_command_responder_top.sv @@
// ps2 mouse device side: reply byte queue with command responder
// steps: accept, push n reply bytes (0..3) or pop one for a read, finish, registered result strobe
// a new word is taken only in idle; the single queue write port takes one byte a cycle
// busy stays high from accept until the cycle the result strobe shows; results cannot be stalled
// reset: synchronous active low, empties the queue and disables reporting; no clearing pass
module ps2_mouse_command_responder_top #(
    parameter int QUEUE_DEPTH = ps2m_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_command_byte,
    input  logic [7:0] i_button_status,
    input  logic [7:0] i_delta_x,
    input  logic [7:0] i_delta_y,
    output logic       o_strobe,
    output logic [7:0] o_read_data,
    output logic       o_read_valid,
    output logic       o_byte_pending
);
    import ps2m_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F  = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW:0]   DEPTH_S  = (FW + 1)'(QUEUE_DEPTH);

    t_state         r_state, n_state;
    t_ctrl          ctrl;

    logic [7:0]     r_mem [QUEUE_DEPTH];
    logic [7:0]     r_mem_q;
    logic [AW-1:0]  r_head, n_head;
    logic [FW-1:0]  r_fill, n_fill;
    logic           r_report, n_report;
    logic [7:0]     r_bytes [3];
    logic [7:0]     n_bytes [3];
    logic [1:0]     r_cnt, n_cnt;
    logic [7:0]     r_rd_data, n_rd_data;
    logic           r_rd_valid, n_rd_valid;
    logic           r_strobe;
    logic [7:0]     r_out_data;
    logic           r_out_valid;
    logic           r_out_pending;

    logic [7:0]     ld_bytes [3];
    logic [1:0]     ld_cnt;
    logic           ld_report;
    logic [FW:0]    slot_sum;
    logic [FW:0]    slot_wrap;
    logic [AW-1:0]  slot;
    logic           not_full;

    // byte list and flag for an arriving word
    always_comb begin
        ld_bytes[0] = REPLY_ACK;
        ld_bytes[1] = REPLY_ID;
        ld_bytes[2] = REPLY_ID;
        ld_cnt      = 2'd0;
        ld_report   = r_report;
        case (i_opcode)
            OP_HOST_CMD: begin
                ld_cnt = 2'd1;
                case (i_command_byte)
                    CMD_RESET: begin
                        ld_bytes[1] = REPLY_SELF_TEST;
                        ld_cnt      = 2'd3;
                        ld_report   = 1'b0;
                    end
                    CMD_SET_DEFAULTS: ld_report = 1'b0;
                    CMD_DISABLE:      ld_report = 1'b0;
                    CMD_ENABLE:       ld_report = 1'b1;
                    CMD_GET_ID:       ld_cnt    = 2'd2;
                    default:          ld_cnt    = 2'd1;
                endcase
            end
            OP_MOVEMENT: begin
                ld_bytes[0] = i_button_status;
                ld_bytes[1] = i_delta_x;
                ld_bytes[2] = i_delta_y;
                ld_cnt      = r_report ? 2'd3 : 2'd0;
            end
            OP_SOFT_RST: ld_report = 1'b0;
            default:     ld_cnt    = 2'd0;
        endcase
    end

    // tail slot: head + fill, wrapped once
    always_comb begin
        slot_sum  = (FW + 1)'(r_head) + (FW + 1)'(r_fill);
        slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
        slot      = slot_wrap[AW-1:0];
        not_full  = (r_fill != DEPTH_F);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_READ) begin
                        n_state = ST_READ;
                    end else if (ld_cnt != 2'd0) begin
                        n_state = ST_PUSH;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_PUSH: begin
                if (r_cnt == 2'd1) begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ:   n_state = ST_FINISH;
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl.accept = 1'b0;
        ctrl.push   = 1'b0;
        ctrl.pop    = 1'b0;
        ctrl.finish = 1'b0;
        busy        = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy        = 1'b0;
                ctrl.accept = start;
            end
            ST_PUSH:   ctrl.push   = 1'b1;
            ST_READ:   ctrl.pop    = (r_fill != '0);
            ST_FINISH: ctrl.finish = 1'b1;
            default:   busy        = 1'b1;
        endcase
    end

    // datapath next values
    always_comb begin
        n_head     = r_head;
        n_fill     = r_fill;
        n_report   = r_report;
        n_bytes    = r_bytes;
        n_cnt      = r_cnt;
        n_rd_data  = r_rd_data;
        n_rd_valid = r_rd_valid;
        if (ctrl.accept) begin
            n_bytes    = ld_bytes;
            n_cnt      = ld_cnt;
            n_report   = ld_report;
            n_rd_data  = 8'd0;
            n_rd_valid = 1'b0;
            if (i_opcode == OP_SOFT_RST) begin
                n_head = '0;
                n_fill = '0;
            end
        end
        if (ctrl.push) begin
            n_bytes[0] = r_bytes[1];
            n_bytes[1] = r_bytes[2];
            n_cnt      = r_cnt - 2'd1;
            if (not_full) begin
                n_fill = r_fill + FW'(1);
            end
        end
        if (ctrl.pop) begin
            n_rd_data  = r_mem_q;
            n_rd_valid = 1'b1;
            n_head     = (r_head == LAST_IDX) ? '0 : (r_head + AW'(1));
            n_fill     = r_fill - FW'(1);
        end
    end

    // reply queue storage
    always_ff @(posedge i_clk) begin
        if (ctrl.push && not_full) begin
            r_mem[slot] <= r_bytes[0];
        end
        r_mem_q <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head        <= '0;
            r_fill        <= '0;
            r_report      <= 1'b0;
            r_cnt         <= 2'd0;
            r_strobe      <= 1'b0;
            r_out_data    <= 8'd0;
            r_out_valid   <= 1'b0;
            r_out_pending <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_report <= n_report;
            r_cnt    <= n_cnt;
            r_strobe <= ctrl.finish;
            if (ctrl.finish) begin
                r_out_data    <= r_rd_data;
                r_out_valid   <= r_rd_valid;
                r_out_pending <= (r_fill != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes    <= n_bytes;
        r_rd_data  <= n_rd_data;
        r_rd_valid <= n_rd_valid;
    end

    assign o_strobe       = r_strobe;
    assign o_read_data    = r_out_data;
    assign o_read_valid   = r_out_valid;
    assign o_byte_pending = r_out_pending;

endmodule

@@ design/ps2m_checker.sv @@
`include "ps2_mouse_command_responder_top_macros.svh"

module ps2m_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_busy,
    input logic       i_strobe,
    input logic [7:0] i_read_data,
    input logic       i_read_valid
);

    // result shows only once the responder is free again
    `PS2M_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, i_strobe, !i_busy, "strobe while busy")

    // one strobe per word, never two in a row
    `PS2M_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, i_strobe, !i_strobe, "strobe held")

    // accepted word keeps the responder busy and has no result yet
    `PS2M_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy && !i_strobe, "no busy after accept")

    // no popped byte means zero data
    `PS2M_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_strobe && !i_read_valid, i_read_data == 8'd0, "data without pop")

endmodule

bind ps2_mouse_command_responder_top ps2m_checker u_ps2m_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (start),
    .i_busy       (busy),
    .i_strobe     (o_strobe),
    .i_read_data  (o_read_data),
    .i_read_valid (o_read_valid)
);
